/* src/rfrs_pkg.sv */
`timescale 1ns / 1ps

package rfrs_pkg;

  localparam int DEF_POS_FRAC_BITS = 4;
  localparam int DEF_POS_WIDTH     = 28;

  localparam int MODE_W  = 3;
  localparam int VEL_W   = 9;
  localparam int TOL_W   = 13;
  localparam int OUT_DW  = 16;

  localparam logic [TOL_W-1:0] TOL_RESET = 13'd16;

  localparam int VEL_FIRE  = 80;
  localparam int VEL_WIND  = 50;
  localparam int VEL_LIMIT = 200;

  // angles in whole degrees
  localparam int DEG_FIRE       = 80;
  localparam int DEG_FULL_AUTON = 5;
  localparam int DEG_FULL       = 2;
  localparam int DEG_PART       = 5;

  // 360 = 45 * 8, and 2^12 mod 45 == 1
  localparam int TURN_ODD   = 45;
  localparam int TURN_SHIFT = 3;
  localparam int CHUNK_W    = 12;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK      = 3'd0,
    MODE_FIRE      = 3'd1,
    MODE_FIRE_WIND = 3'd2,
    MODE_FIRE_PART = 3'd3,
    MODE_WIND      = 3'd4,
    MODE_WIND_PART = 3'd5,
    MODE_MANUAL    = 3'd6,
    MODE_STOP      = 3'd7
  } mode_t;

  typedef struct packed {
    logic                    emit;
    logic signed [VEL_W-1:0] velocity;
    logic                    busy;
  } rfrs_res_t;

  function automatic int pos_shift(int frac_bits);
    return frac_bits + TURN_SHIFT;
  endfunction

  function automatic int rem_width(int frac_bits);
    return frac_bits + TURN_SHIFT + 6;
  endfunction

  function automatic int chunk_count(int pos_w, int frac_bits);
    return (pos_w - frac_bits - TURN_SHIFT + CHUNK_W - 1) / CHUNK_W;
  endfunction

  function automatic int sum_width(int pos_w, int frac_bits);
    return CHUNK_W + $clog2(chunk_count(pos_w, frac_bits));
  endfunction

  function automatic int recip_shift(int pos_w, int frac_bits);
    return sum_width(pos_w, frac_bits) + 6;
  endfunction

  function automatic int recip_width(int pos_w, int frac_bits);
    return recip_shift(pos_w, frac_bits) - 4;
  endfunction

  function automatic int prod_width(int pos_w, int frac_bits);
    return sum_width(pos_w, frac_bits) + recip_width(pos_w, frac_bits);
  endfunction

endpackage

/* src/rfrs_reduce.sv */
`timescale 1ns / 1ps

module rfrs_reduce #(
  parameter int POS_FRAC_BITS = rfrs_pkg::DEF_POS_FRAC_BITS,
  parameter int POS_WIDTH     = rfrs_pkg::DEF_POS_WIDTH
) (
  input  logic                                                       clk,
  input  logic                                                       load,
  input  logic signed [POS_WIDTH-1:0]                                pos,
  output logic                                                       neg,
  output logic [rfrs_pkg::pos_shift(POS_FRAC_BITS)-1:0]              low,
  output logic [rfrs_pkg::sum_width(POS_WIDTH, POS_FRAC_BITS)-1:0]   sum,
  output logic [rfrs_pkg::prod_width(POS_WIDTH, POS_FRAC_BITS)-1:0]  prod
);

  localparam int SH   = rfrs_pkg::pos_shift(POS_FRAC_BITS);
  localparam int NCH  = rfrs_pkg::chunk_count(POS_WIDTH, POS_FRAC_BITS);
  localparam int CW   = rfrs_pkg::CHUNK_W;
  localparam int SW   = rfrs_pkg::sum_width(POS_WIDTH, POS_FRAC_BITS);
  localparam int K    = rfrs_pkg::recip_shift(POS_WIDTH, POS_FRAC_BITS);
  localparam int PW   = rfrs_pkg::prod_width(POS_WIDTH, POS_FRAC_BITS);
  localparam int MULT = ((1 << K) + rfrs_pkg::TURN_ODD - 1) / rfrs_pkg::TURN_ODD;

  logic [POS_WIDTH-1:0] mag;
  logic [NCH*CW-1:0]    quot;
  logic [SW-1:0]        sum_next;
  logic [PW-1:0]        prod_next;

  // |pos| / 2^SH is reduced mod 45 by adding 12-bit chunks
  always_comb begin
    mag  = pos[POS_WIDTH-1] ? (~pos + 1'b1) : pos;
    quot = (NCH*CW)'(mag >> SH);
    sum_next = '0;
    for (int i = 0; i < NCH; i++) begin
      sum_next = sum_next + SW'(quot[i*CW +: CW]);
    end
    // reciprocal of 45, exact over the whole sum range
    prod_next = PW'(sum_next) * PW'(MULT);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg  <= pos[POS_WIDTH-1];
      low  <= mag[SH-1:0];
      sum  <= sum_next;
      prod <= prod_next;
    end
  end

endmodule

/* src/rfrs_seq.sv */
`timescale 1ns / 1ps

module rfrs_seq #(
  parameter int POS_FRAC_BITS = rfrs_pkg::DEF_POS_FRAC_BITS,
  parameter int POS_WIDTH     = rfrs_pkg::DEF_POS_WIDTH
) (
  input  logic                                                       clk,
  input  logic                                                       rst,
  input  logic                                                       en,
  input  logic [rfrs_pkg::MODE_W-1:0]                                mode,
  input  logic signed [POS_WIDTH-1:0]                                pos,
  input  logic                                                       auton,
  input  logic signed [rfrs_pkg::VEL_W-1:0]                          manual_velocity,
  input  logic [rfrs_pkg::TOL_W-1:0]                                 tol,
  input  logic                                                       neg,
  input  logic [rfrs_pkg::pos_shift(POS_FRAC_BITS)-1:0]              low,
  input  logic [rfrs_pkg::sum_width(POS_WIDTH, POS_FRAC_BITS)-1:0]   sum,
  input  logic [rfrs_pkg::prod_width(POS_WIDTH, POS_FRAC_BITS)-1:0]  prod,
  output rfrs_pkg::rfrs_res_t                                        res
);

  localparam int SH  = rfrs_pkg::pos_shift(POS_FRAC_BITS);
  localparam int RW  = rfrs_pkg::rem_width(POS_FRAC_BITS);
  localparam int SW  = rfrs_pkg::sum_width(POS_WIDTH, POS_FRAC_BITS);
  localparam int K   = rfrs_pkg::recip_shift(POS_WIDTH, POS_FRAC_BITS);
  localparam int PW  = rfrs_pkg::prod_width(POS_WIDTH, POS_FRAC_BITS);
  localparam int EW  = ((POS_WIDTH > RW) ? POS_WIDTH : RW) + 2;
  localparam int TW  = (RW > rfrs_pkg::TOL_W) ? RW : rfrs_pkg::TOL_W;
  localparam int VW  = rfrs_pkg::VEL_W;

  localparam logic signed [EW-1:0] TURN   = EW'(rfrs_pkg::TURN_ODD << SH);
  localparam logic signed [EW-1:0] D_FIRE = EW'(rfrs_pkg::DEG_FIRE << POS_FRAC_BITS);
  localparam logic signed [EW-1:0] D_FULL_AUTON =
    EW'(rfrs_pkg::DEG_FULL_AUTON << POS_FRAC_BITS);
  localparam logic signed [EW-1:0] D_FULL = EW'(rfrs_pkg::DEG_FULL << POS_FRAC_BITS);
  localparam logic signed [EW-1:0] D_PART = EW'(rfrs_pkg::DEG_PART << POS_FRAC_BITS);
  localparam logic signed [EW-1:0] P_MAX  = EW'((longint'(1) << (POS_WIDTH - 1)) - 1);
  localparam logic signed [EW-1:0] P_MIN  = -P_MAX - 1;

  localparam logic signed [VW-1:0] V_FIRE  = VW'(rfrs_pkg::VEL_FIRE);
  localparam logic signed [VW-1:0] V_WIND  = VW'(rfrs_pkg::VEL_WIND);
  localparam logic signed [VW-1:0] V_LIMIT = VW'(rfrs_pkg::VEL_LIMIT);

  function automatic logic signed [POS_WIDTH-1:0] sat_pos(logic signed [EW-1:0] v);
    logic signed [EW-1:0] c;
    c = (v > P_MAX) ? P_MAX : ((v < P_MIN) ? P_MIN : v);
    return c[POS_WIDTH-1:0];
  endfunction

  logic                        moving, moving_next;
  logic signed [POS_WIDTH-1:0] target_position, target_position_next;
  logic signed [VW-1:0]        target_velocity, target_velocity_next;
  logic                        chain_full_wind, chain_full_wind_next;
  logic                        chain_partial_wind, chain_partial_wind_next;

  rfrs_pkg::mode_t             cmd;
  logic [SW-1:0]               quot, quot_x45, r_full;
  logic [5:0]                  r45;
  logic [RW-1:0]               rem_mag, rem_floor;
  logic                        wound;
  logic signed [EW-1:0]        pos_e, rf_e, fire_d, wind_m, wind_base;
  logic signed [POS_WIDTH-1:0] fire_t, full_t, part_t;
  logic signed [VW-1:0]        mv_sat;
  logic                        fire_go;

  always_comb begin
    cmd      = rfrs_pkg::mode_t'(mode);
    quot     = SW'(prod[PW-1:K]);
    quot_x45 = (quot << 5) + (quot << 3) + (quot << 2) + quot;
    r_full   = sum - quot_x45;
    r45      = r_full[5:0];
    rem_mag  = {r45, low};
    // floor remainder in [0, turn)
    rem_floor = (neg && (rem_mag != '0)) ? (RW'(TURN) - rem_mag) : rem_mag;
    wound     = TW'(rem_mag) <= TW'(tol);

    pos_e  = EW'(pos);
    rf_e   = $signed(EW'(rem_floor));
    fire_d = D_FIRE - rf_e;
    if (fire_d < 0) begin
      fire_d = fire_d + TURN;
    end
    fire_t    = sat_pos(pos_e + fire_d);
    wind_m    = (rem_floor == '0) ? '0 : (TURN - rf_e);
    wind_base = pos_e + wind_m;
    full_t    = sat_pos(wind_base + (auton ? D_FULL_AUTON : D_FULL));
    part_t    = sat_pos(wind_base - D_PART);

    if (manual_velocity > V_LIMIT) begin
      mv_sat = V_LIMIT;
    end else if (manual_velocity < -V_LIMIT) begin
      mv_sat = -V_LIMIT;
    end else begin
      mv_sat = manual_velocity;
    end
  end

  always_comb begin
    moving_next             = moving;
    target_position_next    = target_position;
    target_velocity_next    = target_velocity;
    chain_full_wind_next    = chain_full_wind;
    chain_partial_wind_next = chain_partial_wind;
    res.emit     = 1'b0;
    res.velocity = '0;
    fire_go      = 1'b0;

    unique case (cmd)
      rfrs_pkg::MODE_TICK: begin
        if (moving) begin
          res.emit = 1'b1;
          if (target_position > pos) begin
            res.velocity = target_velocity;
          end else begin
            moving_next = 1'b0;
            // full wind takes precedence, partial stays pending
            if (chain_full_wind) begin
              chain_full_wind_next = 1'b0;
              if (!wound) begin
                target_position_next = full_t;
                target_velocity_next = V_WIND;
                moving_next          = 1'b1;
              end
            end else if (chain_partial_wind) begin
              chain_partial_wind_next = 1'b0;
              if (!wound) begin
                target_position_next = part_t;
                target_velocity_next = V_WIND;
                moving_next          = 1'b1;
              end
            end
          end
        end
      end
      rfrs_pkg::MODE_FIRE, rfrs_pkg::MODE_FIRE_WIND, rfrs_pkg::MODE_FIRE_PART: begin
        if (!chain_full_wind) begin
          fire_go              = 1'b1;
          res.emit             = 1'b1;
          res.velocity         = V_FIRE;
          target_position_next = fire_t;
          target_velocity_next = V_FIRE;
          moving_next          = 1'b1;
        end
        if (cmd == rfrs_pkg::MODE_FIRE_WIND) begin
          chain_full_wind_next = 1'b1;
        end
        if (cmd == rfrs_pkg::MODE_FIRE_PART) begin
          chain_partial_wind_next = 1'b1;
        end
      end
      rfrs_pkg::MODE_WIND: begin
        if (!chain_full_wind && !wound) begin
          target_position_next = full_t;
          target_velocity_next = V_WIND;
          moving_next          = 1'b1;
        end
      end
      rfrs_pkg::MODE_WIND_PART: begin
        if (!wound) begin
          target_position_next = part_t;
          target_velocity_next = V_WIND;
          moving_next          = 1'b1;
        end
      end
      rfrs_pkg::MODE_MANUAL: begin
        res.emit     = 1'b1;
        res.velocity = mv_sat;
      end
      rfrs_pkg::MODE_STOP: begin
        res.emit = 1'b1;
      end
    endcase

    res.busy = moving_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      moving             <= 1'b0;
      target_position    <= '0;
      target_velocity    <= '0;
      chain_full_wind    <= 1'b0;
      chain_partial_wind <= 1'b0;
    end else if (en) begin
      moving             <= moving_next;
      target_position    <= target_position_next;
      target_velocity    <= target_velocity_next;
      chain_full_wind    <= chain_full_wind_next;
      chain_partial_wind <= chain_partial_wind_next;
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    en |-> (r45 < 6'(rfrs_pkg::TURN_ODD)))
    else $error("turn remainder out of range");

  a_move_vel: assert property (@(posedge clk) disable iff (rst)
    moving |-> (target_velocity == V_FIRE || target_velocity == V_WIND))
    else $error("moving with unexpected target velocity");

  a_fire_moves: assert property (@(posedge clk) disable iff (rst)
    (en && fire_go) |=> (moving && target_velocity == V_FIRE))
    else $error("fire request did not start a move");

  a_arrive_clears: assert property (@(posedge clk) disable iff (rst)
    (en && cmd == rfrs_pkg::MODE_TICK && moving && !(target_position > pos))
      |=> !chain_full_wind)
    else $error("chained full wind still pending after arrival");

endmodule

/* src/rotary_fire_and_rewind_sequencer_top.sv */
`timescale 1ns / 1ps

// a request passes through the s1 and s2 registers, then its result is held in the output register
// one request per cycle while the output is not stalled; the move state updates as a request leaves s2
// an output register holds a stalled result while two more requests can be taken in
// reset (rst, synchronous) clears moving, target and chained winds, tolerance back to 16
// no clearing pass after reset; requests are taken from the first cycle out of reset
module rotary_fire_and_rewind_sequencer_top #(
  parameter int POS_FRAC_BITS = rfrs_pkg::DEF_POS_FRAC_BITS,
  parameter int POS_WIDTH     = rfrs_pkg::DEF_POS_WIDTH,
  localparam int IN_DW        = ((POS_WIDTH + 1 + rfrs_pkg::VEL_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [rfrs_pkg::TOL_W-1:0]    cfg_wr_data,  // zero_tolerance
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [IN_DW-1:0]              s_tdata,      // position, auton, manual_velocity, zeros
  input  logic [rfrs_pkg::MODE_W-1:0]   s_tuser,      // mode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rfrs_pkg::OUT_DW-1:0]   m_tdata       // velocity, busy_res, zeros
);

  localparam int SH = rfrs_pkg::pos_shift(POS_FRAC_BITS);
  localparam int SW = rfrs_pkg::sum_width(POS_WIDTH, POS_FRAC_BITS);
  localparam int PW = rfrs_pkg::prod_width(POS_WIDTH, POS_FRAC_BITS);
  localparam int VW = rfrs_pkg::VEL_W;

  logic [rfrs_pkg::TOL_W-1:0]  zero_tolerance;

  logic                        s1_valid;
  logic [rfrs_pkg::MODE_W-1:0] s1_mode;
  logic signed [POS_WIDTH-1:0] s1_pos;
  logic                        s1_auton;
  logic signed [VW-1:0]        s1_mv;

  logic                        s2_valid;
  logic [rfrs_pkg::MODE_W-1:0] s2_mode;
  logic signed [POS_WIDTH-1:0] s2_pos;
  logic                        s2_auton;
  logic signed [VW-1:0]        s2_mv;
  logic                        s2_neg;
  logic [SH-1:0]               s2_low;
  logic [SW-1:0]               s2_sum;
  logic [PW-1:0]               s2_prod;

  logic signed [VW-1:0]        out_vel;
  logic                        out_busy;

  logic                        out_free, s2_fire, s1_adv, in_acc;
  rfrs_pkg::rfrs_res_t         res;

  assign out_free = !m_tvalid || m_tready;
  assign s2_fire  = s2_valid && out_free;
  assign s1_adv   = s1_valid && (!s2_valid || out_free);
  assign s_tready = !s1_valid || !s2_valid || out_free;
  assign in_acc   = s_tvalid && s_tready;

  assign m_tdata = {(rfrs_pkg::OUT_DW - VW - 1)'(0), out_busy, out_vel};

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tolerance <= rfrs_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      zero_tolerance <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_fire) begin
        s2_valid <= 1'b0;
      end
      if (out_free) begin
        m_tvalid <= s2_fire && res.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode  <= s_tuser;
      s1_pos   <= s_tdata[POS_WIDTH-1:0];
      s1_auton <= s_tdata[POS_WIDTH];
      s1_mv    <= s_tdata[POS_WIDTH+VW:POS_WIDTH+1];
    end
    if (s1_adv) begin
      s2_mode  <= s1_mode;
      s2_pos   <= s1_pos;
      s2_auton <= s1_auton;
      s2_mv    <= s1_mv;
    end
    if (s2_fire && res.emit) begin
      out_vel  <= res.velocity;
      out_busy <= res.busy;
    end
  end

  rfrs_reduce #(
    .POS_FRAC_BITS (POS_FRAC_BITS),
    .POS_WIDTH     (POS_WIDTH)
  ) u_reduce (
    .clk  (clk),
    .load (s1_adv),
    .pos  (s1_pos),
    .neg  (s2_neg),
    .low  (s2_low),
    .sum  (s2_sum),
    .prod (s2_prod)
  );

  rfrs_seq #(
    .POS_FRAC_BITS (POS_FRAC_BITS),
    .POS_WIDTH     (POS_WIDTH)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .en              (s2_fire),
    .mode            (s2_mode),
    .pos             (s2_pos),
    .auton           (s2_auton),
    .manual_velocity (s2_mv),
    .tol             (zero_tolerance),
    .neg             (s2_neg),
    .low             (s2_low),
    .sum             (s2_sum),
    .prod            (s2_prod),
    .res             (res)
  );

endmodule

/* tb/sv/rotary_fire_and_rewind_sequencer_top_test.sv */
`timescale 1ns / 1ps

module rotary_fire_and_rewind_sequencer_top_test;

  localparam int POS_W = rfrs_pkg::DEF_POS_WIDTH;
  localparam int VEL_W = rfrs_pkg::VEL_W;
  localparam int IN_W = ((POS_W + 1 + VEL_W + 7) / 8) * 8;
  localparam longint UNIT = longint'(1) << rfrs_pkg::DEF_POS_FRAC_BITS;
  localparam longint TURN = 360 * UNIT;
  localparam longint POS_MAX = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_MIN = -POS_MAX - 1;
  localparam int MAX_GAP = 18;
  localparam int SETTLE = 6;
  localparam int IDLE_LIMIT = 600;
  localparam int RAND_PER_PHASE = 160;

  typedef struct {
    logic signed [VEL_W-1:0] vel;
    logic                    busy;
  } vel_cmd_t;

  typedef struct {
    rfrs_pkg::mode_t md;
    longint          pos;
    bit              au;
    int              mv;
    bit              typed;
    bit              t_emit;
    int              t_vel;
    bit              t_busy;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [rfrs_pkg::TOL_W-1:0] cfg_wr_data;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;
  logic [rfrs_pkg::MODE_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [rfrs_pkg::OUT_DW-1:0] m_tdata;

  rotary_fire_and_rewind_sequencer_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // arm model state
  bit     arm_moving = 1'b0;
  longint arm_target = 0;
  int     arm_speed = 0;
  bit     wind_full_pending = 1'b0;
  bit     wind_part_pending = 1'b0;
  longint wound_band = longint'(rfrs_pkg::TOL_RESET);

  vel_cmd_t velocity_cmds[$];
  dir_row_t dir_rows[$];
  int errors = 0;
  int requests = 0;
  int cmds_checked = 0;
  int tol_settings = 0;
  int idle_cycles = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  function automatic longint clamp_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // smallest p >= pos with p congruent to ang (position units) mod one turn
  function automatic longint next_at(longint pos, longint ang);
    longint m;
    m = (ang - pos) % TURN;
    if (m < 0) m += TURN;
    return pos + m;
  endfunction

  function automatic bit is_wound(longint pos);
    longint r;
    r = pos % TURN;
    return r >= -wound_band && r <= wound_band;
  endfunction

  function automatic void start_wind_full(longint pos, bit au);
    if (wind_full_pending || is_wound(pos)) return;
    arm_target = clamp_pos(next_at(pos, 0) +
                           (au ? rfrs_pkg::DEG_FULL_AUTON : rfrs_pkg::DEG_FULL) * UNIT);
    arm_speed = rfrs_pkg::VEL_WIND;
    arm_moving = 1'b1;
  endfunction

  function automatic void start_wind_part(longint pos);
    if (is_wound(pos)) return;
    arm_target = clamp_pos(next_at(pos, 0) - rfrs_pkg::DEG_PART * UNIT);
    arm_speed = rfrs_pkg::VEL_WIND;
    arm_moving = 1'b1;
  endfunction

  function automatic bit start_firing(longint pos);
    if (wind_full_pending) return 1'b0;
    arm_target = clamp_pos(next_at(pos, rfrs_pkg::DEG_FIRE * UNIT));
    arm_speed = rfrs_pkg::VEL_FIRE;
    arm_moving = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit advance_sequencer(input rfrs_pkg::mode_t md, input longint pos,
                                           input bit au, input int mv,
                                           output int vel, output bit busy);
    bit emit;
    emit = 1'b0;
    vel = 0;
    if (mv > rfrs_pkg::VEL_LIMIT) mv = rfrs_pkg::VEL_LIMIT;
    if (mv < -rfrs_pkg::VEL_LIMIT) mv = -rfrs_pkg::VEL_LIMIT;
    case (md)
      rfrs_pkg::MODE_TICK: begin
        if (arm_moving) begin
          emit = 1'b1;
          if (arm_target > pos) begin
            vel = arm_speed;
          end else begin
            arm_moving = 1'b0;
            // full wind wins when both are queued
            if (wind_full_pending) begin
              wind_full_pending = 1'b0;
              start_wind_full(pos, au);
            end else if (wind_part_pending) begin
              wind_part_pending = 1'b0;
              start_wind_part(pos);
            end
          end
        end
      end
      rfrs_pkg::MODE_FIRE: begin
        emit = start_firing(pos);
        vel = rfrs_pkg::VEL_FIRE;
      end
      rfrs_pkg::MODE_FIRE_WIND: begin
        emit = start_firing(pos);
        vel = rfrs_pkg::VEL_FIRE;
        wind_full_pending = 1'b1;
      end
      rfrs_pkg::MODE_FIRE_PART: begin
        emit = start_firing(pos);
        vel = rfrs_pkg::VEL_FIRE;
        wind_part_pending = 1'b1;
      end
      rfrs_pkg::MODE_WIND: start_wind_full(pos, au);
      rfrs_pkg::MODE_WIND_PART: start_wind_part(pos);
      rfrs_pkg::MODE_MANUAL: begin
        emit = 1'b1;
        vel = mv;
      end
      default: begin
        emit = 1'b1;
        vel = 0;
      end
    endcase
    busy = arm_moving;
    return emit;
  endfunction

  task automatic add_row(rfrs_pkg::mode_t md, longint pos, bit au, int mv,
                         bit typed, bit t_emit, int t_vel, bit t_busy);
    dir_row_t row;
    row.md = md;
    row.pos = pos;
    row.au = au;
    row.mv = mv;
    row.typed = typed;
    row.t_emit = t_emit;
    row.t_vel = t_vel;
    row.t_busy = t_busy;
    dir_rows.push_back(row);
  endtask

  task automatic push_request(rfrs_pkg::mode_t md, longint pos, bit au, int mv,
                              bit typed, bit t_emit, int t_vel, bit t_busy);
    int gap;
    bit emit;
    int vel;
    bit busy;
    vel_cmd_t cmd;
    logic [IN_W-1:0] word;
    if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    word = '0;
    word[POS_W-1:0] = pos[POS_W-1:0];
    word[POS_W] = au;
    word[POS_W+1 +: VEL_W] = mv[VEL_W-1:0];
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tuser <= md;
    do @(posedge clk); while (!s_tready);
    requests++;
    emit = advance_sequencer(md, pos, au, mv, vel, busy);
    if (typed) begin
      emit = t_emit;
      vel = t_vel;
      busy = t_busy;
    end
    if (emit) begin
      cmd.vel = vel[VEL_W-1:0];
      cmd.busy = busy;
      velocity_cmds.push_back(cmd);
    end
  endtask

  // hold off the sender until every velocity command is out and the pipe is empty
  task automatic drain_pipe();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (velocity_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_tolerance(int v);
    drain_pipe();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v[rfrs_pkg::TOL_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    wound_band = longint'(v);
    tol_settings++;
  endtask

  // receiver
  initial begin
    int wait_cycles;
    m_tready = 1'b0;
    forever begin
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      wait_cycles = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (wait_cycles > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (wait_cycles - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    vel_cmd_t cmd;
    if (!rst && m_tvalid && m_tready) begin
      if (velocity_cmds.size() == 0) begin
        $error("unexpected velocity command %0d", $signed(m_tdata[VEL_W-1:0]));
        errors++;
      end else begin
        cmd = velocity_cmds.pop_front();
        if (m_tdata[VEL_W-1:0] !== cmd.vel) begin
          $error("velocity: expected %0d, got %0d", cmd.vel, $signed(m_tdata[VEL_W-1:0]));
          errors++;
        end
        if (m_tdata[VEL_W] !== cmd.busy) begin
          $error("busy_res: expected %0d, got %0d", cmd.busy, m_tdata[VEL_W]);
          errors++;
        end
        cmds_checked++;
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d velocity commands outstanding", velocity_cmds.size());
      $display("rotary_fire_and_rewind_sequencer_top_test: errors");
      $finish;
    end
  end

  initial begin
    int counted;
    int r;
    int mv;
    int tol;
    bit au;
    rfrs_pkg::mode_t md;
    longint pos;
    longint arm_pos;
    logic signed [POS_W-1:0] rpos;
    logic signed [VEL_W-1:0] rmv;

    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = rfrs_pkg::MODE_TICK;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed sequence, tolerance at its reset value
    add_row(rfrs_pkg::MODE_TICK,      0,       0, 0,    1, 0, 0, 0);
    add_row(rfrs_pkg::MODE_STOP,      0,       0, 0,    1, 1, 0, 0);
    add_row(rfrs_pkg::MODE_MANUAL,    0,       0, 200,  1, 1, 200, 0);
    add_row(rfrs_pkg::MODE_MANUAL,    0,       1, -256, 1, 1, -200, 0);
    add_row(rfrs_pkg::MODE_MANUAL,    0,       0, 255,  1, 1, 200, 0);
    add_row(rfrs_pkg::MODE_WIND,      0,       0, 0,    1, 0, 0, 0);
    add_row(rfrs_pkg::MODE_WIND_PART, -16,     0, 0,    1, 0, 0, 0);
    add_row(rfrs_pkg::MODE_WIND,      TURN+16, 1, 0,    1, 0, 0, 0);
    add_row(rfrs_pkg::MODE_FIRE,      0,       0, 0,    1, 1, rfrs_pkg::VEL_FIRE, 1);
    add_row(rfrs_pkg::MODE_TICK,      0,       0, 0,    0, 0, 0, 0);
    add_row(rfrs_pkg::MODE_TICK,      1280,    0, 0,    0, 0, 0, 0);
    add_row(rfrs_pkg::MODE_FIRE_WIND, 1280,    0, 0,    0, 0, 0, 0);
    // fire and full wind are locked out while a full wind is queued
    add_row(rfrs_pkg::MODE_FIRE,      0,       0, 0,    1, 0, 0, 0);
    add_row(rfrs_pkg::MODE_WIND,      100,     0, 0,    1, 0, 0, 0);
    add_row(rfrs_pkg::MODE_TICK,      1280,    1, 0,    0, 0, 0, 0);
    add_row(rfrs_pkg::MODE_TICK,      6000,    0, 0,    0, 0, 0, 0);
    // both winds queued
    add_row(rfrs_pkg::MODE_FIRE_PART, -100,    0, 0,    0, 0, 0, 0);
    add_row(rfrs_pkg::MODE_FIRE_WIND, -100,    0, 0,    0, 0, 0, 0);
    add_row(rfrs_pkg::MODE_TICK,      2000,    1, 0,    0, 0, 0, 0);
    add_row(rfrs_pkg::MODE_TICK,      6000,    0, 0,    0, 0, 0, 0);
    add_row(rfrs_pkg::MODE_TICK,      11500,   0, 0,    0, 0, 0, 0);
    // partial target just behind the arm
    add_row(rfrs_pkg::MODE_WIND_PART, 5750,    0, 0,    0, 0, 0, 0);
    add_row(rfrs_pkg::MODE_TICK,      5750,    0, 0,    0, 0, 0, 0);
    // saturating targets
    add_row(rfrs_pkg::MODE_FIRE,      POS_MAX, 0, 0,    0, 0, 0, 0);
    add_row(rfrs_pkg::MODE_TICK,      POS_MAX, 1, 0,    0, 0, 0, 0);
    add_row(rfrs_pkg::MODE_FIRE,      POS_MIN, 0, -1,   0, 0, 0, 0);
    add_row(rfrs_pkg::MODE_WIND_PART, POS_MAX, 0, 0,    0, 0, 0, 0);

    foreach (dir_rows[i])
      push_request(dir_rows[i].md, dir_rows[i].pos, dir_rows[i].au, dir_rows[i].mv,
                   dir_rows[i].typed, dir_rows[i].t_emit, dir_rows[i].t_vel,
                   dir_rows[i].t_busy);

    arm_pos = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: tol = 0;
        1: tol = 5759;
        2: tol = $urandom_range(0, 5759);
        3: tol = $urandom_range(0, 100);
        default: tol = int'(rfrs_pkg::TOL_RESET);
      endcase
      write_tolerance(tol);
      counted = 0;
      while (counted < RAND_PER_PHASE) begin
        if (ph == 2 && counted == RAND_PER_PHASE / 2) drain_pipe();
        r = $urandom_range(0, 99);
        au = 1'($urandom_range(0, 1));
        mv = $urandom_range(0, 2 * rfrs_pkg::VEL_LIMIT) - rfrs_pkg::VEL_LIMIT;
        if (r < 12) begin
          // noise over the whole field ranges
          md = rfrs_pkg::mode_t'($urandom_range(0, 7));
          rpos = POS_W'($urandom);
          pos = rpos;
          rmv = VEL_W'($urandom);
          mv = rmv;
        end else if (arm_moving && r < 75) begin
          md = rfrs_pkg::MODE_TICK;
          case ($urandom_range(0, 7))
            0: arm_pos = arm_target;
            1: arm_pos = arm_target - 1;
            2: arm_pos = arm_pos + $urandom_range(0, 3000);
            default: arm_pos = arm_pos + $urandom_range(0, 400);
          endcase
          arm_pos = clamp_pos(arm_pos);
          pos = arm_pos;
        end else begin
          case ($urandom_range(0, 15))
            0: arm_pos = POS_MAX - $urandom_range(0, 9000);
            1: arm_pos = POS_MIN + $urandom_range(0, 9000);
            2, 3, 4: arm_pos = (longint'($urandom_range(0, 100)) - 50) * TURN
                               + $urandom_range(0, 100) - 50;
            5: arm_pos = longint'($urandom_range(0, 400000)) - 200000;
            default: ;
          endcase
          case ($urandom_range(0, 13))
            0, 1, 2: md = rfrs_pkg::MODE_FIRE;
            3, 4: md = rfrs_pkg::MODE_FIRE_WIND;
            5, 6: md = rfrs_pkg::MODE_FIRE_PART;
            7, 8: md = rfrs_pkg::MODE_WIND;
            9, 10: md = rfrs_pkg::MODE_WIND_PART;
            11, 12: md = rfrs_pkg::MODE_MANUAL;
            default: md = rfrs_pkg::MODE_STOP;
          endcase
          pos = arm_pos;
        end
        if (md != rfrs_pkg::MODE_TICK || arm_moving) counted++;
        push_request(md, pos, au, mv, 0, 0, 0, 0);
      end
    end

    drain_pipe();
    $display("%0d requests, %0d velocity commands checked over %0d tolerance settings",
             requests, cmds_checked, tol_settings);
    if (errors == 0) begin
      $display("rotary_fire_and_rewind_sequencer_top_test: clean");
    end else begin
      $display("rotary_fire_and_rewind_sequencer_top_test: errors");
    end
    $finish;
  end

endmodule
